FILE: rtl/core/hwd_pkg.sv
`default_nettype none

package hwd_pkg;

   // Field widths of the word formats
   localparam int IDX_W      = 9;
   localparam int SYM_W      = 8;
   localparam int CNT_W      = 32;
   localparam int BYTE_W     = 8;
   localparam int BIT_CNT_W  = 4;

   // Request opcodes
   localparam logic [1:0] OP_LOAD   = 2'd0;
   localparam logic [1:0] OP_START  = 2'd1;
   localparam logic [1:0] OP_DECODE = 2'd2;

   // Classified command kinds handed from front to back
   typedef enum logic [1:0] {
      CMD_LOAD,
      CMD_START,
      CMD_DECODE
   } cmd_kind_type;

   // One entry of the code tree table
   typedef struct packed {
      logic [IDX_W-1:0] left;
      logic [IDX_W-1:0] right;
      logic             leaf;
      logic [SYM_W-1:0] sym;
   } node_type;

   // Command word held in the queue between front and back
   typedef struct packed {
      cmd_kind_type      kind;
      logic [IDX_W-1:0]  index;
      node_type          node;
      logic [CNT_W-1:0]  total;
      logic [BYTE_W-1:0] code;
   } cmd_type;

endpackage

`default_nettype wire

FILE: rtl/core/hwd_ram.sv
`default_nettype none

module hwd_ram #(
   parameter int WIDTH = 27,
   parameter int DEPTH = 512
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Single write port, single registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

FILE: rtl/core/hwd_front.sv
`default_nettype none

module hwd_front
   import hwd_pkg::*;
#(
   parameter int NODE_COUNT = 512
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire logic [1:0]        req_opcode,
   input  wire logic [IDX_W-1:0]  req_node_index,
   input  wire logic [IDX_W-1:0]  req_node_left,
   input  wire logic [IDX_W-1:0]  req_node_right,
   input  wire logic              req_node_is_leaf,
   input  wire logic [SYM_W-1:0]  req_node_symbol,
   input  wire logic [CNT_W-1:0]  req_symbol_total,
   input  wire logic [BYTE_W-1:0] req_code_byte,
   output logic                   cmd_valid,
   output cmd_type                cmd,
   input  wire logic              cmd_ready
);

   cmd_type     entry_ff [2];
   cmd_type     cls;
   logic        keep;
   logic        push;
   logic        pop;
   logic [31:0] idx_ext;
   logic [1:0]  count_ff, count_in;
   logic        wr_ptr_ff, wr_ptr_in;
   logic        rd_ptr_ff, rd_ptr_in;

   assign idx_ext = 32'(req_node_index);

   // Classify the request word; unused opcodes and out-of-table loads are dropped
   always_comb begin
      cls.index      = req_node_index;
      cls.node.left  = req_node_left;
      cls.node.right = req_node_right;
      cls.node.leaf  = req_node_is_leaf;
      cls.node.sym   = req_node_symbol;
      cls.total      = req_symbol_total;
      cls.code       = req_code_byte;
      cls.kind       = CMD_DECODE;
      keep           = 1'b0;
      unique case (req_opcode)
         OP_LOAD: begin
            cls.kind = CMD_LOAD;
            keep     = idx_ext < 32'(NODE_COUNT);
         end
         OP_START: begin
            cls.kind = CMD_START;
            keep     = 1'b1;
         end
         OP_DECODE: begin
            cls.kind = CMD_DECODE;
            keep     = 1'b1;
         end
         default: begin
            keep = 1'b0;
         end
      endcase
   end

   // Two-entry command queue
   assign req_ready = count_ff != 2'd2;
   assign push      = req_valid && req_ready && keep;
   assign cmd_valid = count_ff != 2'd0;
   assign cmd       = entry_ff[rd_ptr_ff];
   assign pop       = cmd_valid && cmd_ready;

   assign count_in  = count_ff + 2'(push) - 2'(pop);
   assign wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
   assign rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= cls;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= 2'd0;
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
      end else begin
         count_ff  <= count_in;
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/core/hwd_back.sv
`default_nettype none

module hwd_back
   import hwd_pkg::*;
#(
   parameter int NODE_COUNT = 512
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic [IDX_W-1:0] root_node,
   input  wire logic             cmd_valid,
   input  wire cmd_type          cmd,
   output logic                  cmd_ready,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output logic      [SYM_W-1:0] rsp_symbol,
   output logic                  rsp_last,
   output logic                  rsp_stream_done
);

   localparam int AW = $clog2(NODE_COUNT);

   typedef enum logic [1:0] {
      S_IDLE,
      S_WALK,
      S_DRAIN
   } state_type;

   state_type             state_ff, state_in;
   logic [IDX_W-1:0]      cur_ff, cur_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic [BYTE_W-1:0]     byte_ff, byte_in;
   logic [BIT_CNT_W-1:0]  bit_cnt_ff, bit_cnt_in;
   logic                  check_ff, check_in;
   logic                  range_ff, range_in;
   logic                  pend_valid_ff, pend_valid_in;
   logic [SYM_W-1:0]      pend_sym_ff, pend_sym_in;
   logic                  pend_done_ff, pend_done_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [SYM_W-1:0]      rsp_symbol_ff, rsp_symbol_in;
   logic                  rsp_last_ff, rsp_last_in;
   logic                  rsp_done_ff, rsp_done_in;

   logic                  rd_en;
   logic [IDX_W-1:0]      rd_idx;
   logic [IDX_W-1:0]      next_idx;
   logic [31:0]           rd_idx_ext;
   logic [31:0]           wr_idx_ext;
   logic                  wr_en;
   node_type              node_raw;
   node_type              node;
   logic                  out_free;
   logic                  push;
   logic                  push_last;
   logic                  leaf_hit;
   logic                  emit;
   logic                  bits_done;
   logic                  stall;

   // Node table
   assign rd_idx_ext = 32'(rd_idx);
   assign wr_idx_ext = 32'(cmd.index);

   hwd_ram #(
      .WIDTH ($bits(node_type)),
      .DEPTH (NODE_COUNT)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_idx_ext[AW-1:0]),
      .wr_data (cmd.node),
      .rd_en   (rd_en),
      .rd_addr (rd_idx_ext[AW-1:0]),
      .rd_data (node_raw)
   );

   // Indices past the table read as an empty inner node
   assign node      = range_ff ? node_raw : '0;
   assign range_in  = rd_en ? (rd_idx_ext < 32'(NODE_COUNT)) : range_ff;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign leaf_hit  = check_ff && node.leaf;
   assign emit      = leaf_hit && (count_ff != '0);
   assign bits_done = bit_cnt_ff == BIT_CNT_W'(BYTE_W);
   assign stall     = (state_ff == S_WALK) && emit && pend_valid_ff && !out_free;
   assign next_idx  = byte_ff[BYTE_W-1] ? node.right : node.left;

   // Sequencer: one tree step per cycle while not stalled by the output; after a leaf the root is reread
   always_comb begin
      state_in      = state_ff;
      cur_in        = cur_ff;
      count_in      = count_ff;
      byte_in       = byte_ff;
      bit_cnt_in    = bit_cnt_ff;
      check_in      = check_ff;
      pend_valid_in = pend_valid_ff;
      pend_sym_in   = pend_sym_ff;
      pend_done_in  = pend_done_ff;
      cmd_ready     = 1'b0;
      rd_en         = 1'b0;
      rd_idx        = cur_ff;
      wr_en         = 1'b0;
      push          = 1'b0;
      push_last     = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            cmd_ready = 1'b1;
            if (cmd_valid) begin
               unique case (cmd.kind)
                  CMD_LOAD: begin
                     wr_en = 1'b1;
                  end
                  CMD_START: begin
                     count_in = cmd.total;
                     cur_in   = root_node;
                  end
                  CMD_DECODE: begin
                     rd_en      = 1'b1;
                     rd_idx     = cur_ff;
                     byte_in    = cmd.code;
                     bit_cnt_in = '0;
                     check_in   = 1'b0;
                     state_in   = S_WALK;
                  end
                  default: begin
                  end
               endcase
            end
         end

         S_WALK: begin
            if (!stall) begin
               // Leaf with symbols still owed: hand the older pending word on
               if (emit) begin
                  if (pend_valid_ff) begin
                     push      = 1'b1;
                     push_last = 1'b0;
                  end
                  pend_valid_in = 1'b1;
                  pend_sym_in   = node.sym;
                  pend_done_in  = count_ff == 32'd1;
                  count_in      = count_ff - 32'd1;
               end
               if (leaf_hit) begin
                  cur_in = root_node;
                  if (bits_done) begin
                     state_in = S_DRAIN;
                  end else begin
                     rd_en    = 1'b1;
                     rd_idx   = root_node;
                     check_in = 1'b0;
                  end
               end else if (bits_done) begin
                  state_in = S_DRAIN;
               end else begin
                  // Take one code bit, MSB first
                  cur_in     = next_idx;
                  rd_en      = 1'b1;
                  rd_idx     = next_idx;
                  byte_in    = {byte_ff[BYTE_W-2:0], 1'b0};
                  bit_cnt_in = bit_cnt_ff + 1'b1;
                  check_in   = 1'b1;
               end
            end
         end

         S_DRAIN: begin
            if (!pend_valid_ff) begin
               state_in = S_IDLE;
            end else if (out_free) begin
               push          = 1'b1;
               push_last     = 1'b1;
               pend_valid_in = 1'b0;
               state_in      = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Output register
   always_comb begin
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_symbol_in = rsp_symbol_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_done_in   = rsp_done_ff;
      if (push) begin
         rsp_valid_in  = 1'b1;
         rsp_symbol_in = pend_sym_ff;
         rsp_last_in   = push_last;
         rsp_done_in   = pend_done_ff;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff       <= byte_in;
      range_ff      <= range_in;
      pend_sym_ff   <= pend_sym_in;
      pend_done_ff  <= pend_done_in;
      rsp_symbol_ff <= rsp_symbol_in;
      rsp_last_ff   <= rsp_last_in;
      rsp_done_ff   <= rsp_done_in;
      if (reset) begin
         state_ff      <= S_IDLE;
         cur_ff        <= '0;
         count_ff      <= '0;
         bit_cnt_ff    <= '0;
         check_ff      <= 1'b0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cur_ff        <= cur_in;
         count_ff      <= count_in;
         bit_cnt_ff    <= bit_cnt_in;
         check_ff      <= check_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_symbol      = rsp_symbol_ff;
   assign rsp_last        = rsp_last_ff;
   assign rsp_stream_done = rsp_done_ff;

   // Count only ever steps down by one while walking
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_WALK) |=>
         (count_ff == $past(count_ff)) || (count_ff == $past(count_ff) - 32'd1))
      else $error("symbol count moved by more than one in a walk step");

   // Bit counter never runs past the byte
   a_bit_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_WALK) |-> (bit_cnt_ff <= BIT_CNT_W'(BYTE_W)))
      else $error("bit counter overran the code byte");

   // A word flagged stream done leaves only with the count exhausted
   a_done_zero: assert property (@(posedge clock) disable iff (reset)
      (push && pend_done_ff) |-> (count_ff == '0))
      else $error("stream done sent while symbols remain");

   // Every leaf taken sends the walk back to the root
   a_reroot: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_WALK && leaf_hit && !stall) |=> (cur_ff == $past(root_node)))
      else $error("walk did not return to root after a leaf");

endmodule

`default_nettype wire

FILE: rtl/core/huffman_tree_walk_decoder.sv
// Huffman tree-walk decoder.
// csr_ channel: one write word sets the root node index (reset 0); csr_ready
//   is always high. Write it only while the block is idle.
// req_ channel: each word is a node load, a stream start (symbol count, walk
//   reset to the root) or one code byte, decoded MSB first. Each step of a
//   byte's walk is one dependent read of the node table RAM (registered read),
//   and each leaf reached before the byte's last bit adds a reread of the root.
// A two-word command queue sits in front of the sequencer, so requests keep
//   being taken while a byte is decoded, until the queue is full.
// rsp_ channel: one word per decoded symbol; last marks the final symbol of
//   a code byte, stream_done the symbol that exhausts the count. A symbol is
//   held until the byte's next symbol is found or the byte ends, and only then
//   moves into the output register.
// A stalled receiver holds the output register; the sequencer then stops at
//   the next symbol it must hand on, and the queue backs up to req_ready.
// Reset clears the count, walk position, queue and output; the node table
//   content is undefined until loaded.
`default_nettype none

module huffman_tree_walk_decoder
   import hwd_pkg::*;
#(
   parameter int NODE_COUNT = 512
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              csr_valid,
   output logic                   csr_ready,
   input  wire logic [IDX_W-1:0]  csr_root_node,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire logic [1:0]        req_opcode,
   input  wire logic [IDX_W-1:0]  req_node_index,
   input  wire logic [IDX_W-1:0]  req_node_left,
   input  wire logic [IDX_W-1:0]  req_node_right,
   input  wire logic              req_node_is_leaf,
   input  wire logic [SYM_W-1:0]  req_node_symbol,
   input  wire logic [CNT_W-1:0]  req_symbol_total,
   input  wire logic [BYTE_W-1:0] req_code_byte,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output logic      [SYM_W-1:0]  rsp_symbol,
   output logic                   rsp_last,
   output logic                   rsp_stream_done
);

   logic [IDX_W-1:0] root_ff, root_in;
   logic             cmd_valid;
   logic             cmd_ready;
   cmd_type          cmd;

   // Root index register
   assign csr_ready = 1'b1;
   assign root_in   = (csr_valid && csr_ready) ? csr_root_node : root_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         root_ff <= '0;
      end else begin
         root_ff <= root_in;
      end
   end

   hwd_front #(
      .NODE_COUNT (NODE_COUNT)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_opcode       (req_opcode),
      .req_node_index   (req_node_index),
      .req_node_left    (req_node_left),
      .req_node_right   (req_node_right),
      .req_node_is_leaf (req_node_is_leaf),
      .req_node_symbol  (req_node_symbol),
      .req_symbol_total (req_symbol_total),
      .req_code_byte    (req_code_byte),
      .cmd_valid        (cmd_valid),
      .cmd              (cmd),
      .cmd_ready        (cmd_ready)
   );

   hwd_back #(
      .NODE_COUNT (NODE_COUNT)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .root_node       (root_ff),
      .cmd_valid       (cmd_valid),
      .cmd             (cmd),
      .cmd_ready       (cmd_ready),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_symbol      (rsp_symbol),
      .rsp_last        (rsp_last),
      .rsp_stream_done (rsp_stream_done)
   );

endmodule

`default_nettype wire

FILE: tb/sv/huffman_tree_walk_decoder_tb.sv
`default_nettype none

module huffman_tree_walk_decoder_tb
   import hwd_pkg::*;
();

   localparam int            TAB_DEPTH = 1 << IDX_W;
   localparam bit [1:0]      OP_SPARE  = 2'd3;     // unused opcode, must be ignored
   localparam int            DRAIN_CYC = 80;       // queue of two plus a byte in flight
   localparam int            HOLD_CYC  = 400;      // long receiver hold-off
   localparam int            RAND_REQS = 350;

   // One request word as driven on the req_ channel
   typedef struct packed {
      bit [1:0]        op;
      bit [IDX_W-1:0]  idx;
      bit [IDX_W-1:0]  left;
      bit [IDX_W-1:0]  right;
      bit              leaf;
      bit [SYM_W-1:0]  sym;
      bit [CNT_W-1:0]  total;
      bit [BYTE_W-1:0] code;
   } req_word_type;

   // One decoded symbol word as seen on the rsp_ channel
   typedef struct packed {
      bit [SYM_W-1:0] symbol;
      bit             last;
      bit             stream_done;
   } sym_word_type;

   typedef struct packed {
      bit [IDX_W-1:0] left;
      bit [IDX_W-1:0] right;
      bit             leaf;
      bit [SYM_W-1:0] sym;
   } tree_entry_type;

   // Directed row: typed rows carry n copies of one symbol, done on the tail or not
   typedef struct packed {
      req_word_type   w;
      bit             typed;
      bit [3:0]       exp_n;
      bit [SYM_W-1:0] exp_sym;
      bit             done_on_tail;
   } dir_row_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              csr_valid = 1'b0;
   logic              csr_ready;
   logic [IDX_W-1:0]  csr_root = '0;
   logic              req_valid = 1'b0;
   logic              req_ready;
   logic [1:0]        req_opcode = '0;
   logic [IDX_W-1:0]  req_node_index = '0;
   logic [IDX_W-1:0]  req_node_left = '0;
   logic [IDX_W-1:0]  req_node_right = '0;
   logic              req_node_is_leaf = 1'b0;
   logic [SYM_W-1:0]  req_node_symbol = '0;
   logic [CNT_W-1:0]  req_symbol_total = '0;
   logic [BYTE_W-1:0] req_code_byte = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   logic [SYM_W-1:0]  rsp_symbol;
   logic              rsp_last;
   logic              rsp_stream_done;

   // Shadow of the decoder state
   tree_entry_type tree_tab [0:TAB_DEPTH-1];
   bit [IDX_W-1:0] walk_pos   = '0;
   bit [CNT_W-1:0] count_left = '0;
   bit [IDX_W-1:0] root_sel   = '0;

   sym_word_type pending_syms [$];
   sym_word_type step_syms [$];
   req_word_type live_tree [$];
   dir_row_type  dir_rows [$];
   bit           taken [0:TAB_DEPTH-1];

   bit steady       = 1'b0;
   bit rx_hold_req  = 1'b0;
   bit rx_hold_done = 1'b0;
   int rx_hold_left = 0;

   int err_count       = 0;
   int items_fed       = 0;
   int bytes_fed       = 0;
   int symbols_checked = 0;
   int roots_set       = 0;

   huffman_tree_walk_decoder dut (
      .clock            (clock),
      .reset            (reset),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_root_node    (csr_root),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_opcode       (req_opcode),
      .req_node_index   (req_node_index),
      .req_node_left    (req_node_left),
      .req_node_right   (req_node_right),
      .req_node_is_leaf (req_node_is_leaf),
      .req_node_symbol  (req_node_symbol),
      .req_symbol_total (req_symbol_total),
      .req_code_byte    (req_code_byte),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_symbol       (rsp_symbol),
      .rsp_last         (rsp_last),
      .rsp_stream_done  (rsp_stream_done)
   );

   always #1 clock = ~clock;

   initial begin
      #1000000;
      $display("FAILURE");
      $finish;
   end

   // Symbols a request word yields, left in step_syms; walks the code tree MSB first
   function automatic void decode_word(input req_word_type w);
      bit [IDX_W-1:0] nxt;
      sym_word_type   tail;
      step_syms.delete();
      case (w.op)
         OP_LOAD: tree_tab[w.idx] = '{w.left, w.right, w.leaf, w.sym};
         OP_START: begin
            count_left = w.total;
            walk_pos   = root_sel;
         end
         OP_DECODE: begin
            for (int b = BYTE_W - 1; b >= 0; b--) begin
               nxt      = w.code[b] ? tree_tab[walk_pos].right : tree_tab[walk_pos].left;
               walk_pos = nxt;
               if (tree_tab[nxt].leaf) begin
                  // exhausted count: leaf still returns to the root, nothing emitted
                  if (count_left != 0) begin
                     count_left = count_left - 1;
                     step_syms.push_back('{tree_tab[nxt].sym, 1'b0, count_left == 0});
                  end
                  walk_pos = root_sel;
               end
            end
            if (step_syms.size() != 0) begin
               tail      = step_syms.pop_back();
               tail.last = 1'b1;
               step_syms.push_back(tail);
            end
         end
         default: ;
      endcase
   endfunction

   function automatic req_word_type rand_word(input bit [1:0] op);
      req_word_type w;
      w.op    = op;
      w.idx   = IDX_W'($urandom);
      w.left  = IDX_W'($urandom);
      w.right = IDX_W'($urandom);
      w.leaf  = 1'($urandom);
      w.sym   = SYM_W'($urandom);
      w.total = $urandom;
      w.code  = BYTE_W'($urandom);
      return w;
   endfunction

   function automatic bit [IDX_W-1:0] fresh_index();
      bit [IDX_W-1:0] i;
      do i = IDX_W'($urandom); while (taken[i]);
      taken[i] = 1'b1;
      return i;
   endfunction

   function automatic bit [CNT_W-1:0] pick_total();
      int r;
      r = $urandom_range(99);
      if (r < 10) return '0;
      if (r < 20) return '1;
      if (r < 30) return $urandom;
      return CNT_W'($urandom_range(1, 30));
   endfunction

   function automatic dir_row_type mk_row(input bit [1:0] op, input int idx, input int l,
                                         input int r, input bit leaf, input int sym,
                                         input bit [CNT_W-1:0] total, input int code);
      dir_row_type row;
      row.w            = '{op, IDX_W'(idx), IDX_W'(l), IDX_W'(r), leaf, SYM_W'(sym),
                           total, BYTE_W'(code)};
      row.typed        = 1'b0;
      row.exp_n        = '0;
      row.exp_sym      = '0;
      row.done_on_tail = 1'b0;
      return row;
   endfunction

   function automatic dir_row_type expect_same(input dir_row_type row, input int n,
                                              input int sym, input bit done_on_tail);
      row.typed        = 1'b1;
      row.exp_n        = 4'(n);
      row.exp_sym      = SYM_W'(sym);
      row.done_on_tail = done_on_tail;
      return row;
   endfunction

   task automatic flag_error(input string msg);
      err_count++;
      if (err_count <= 10) $display("ERROR: %s", msg);
   endtask

   // Offer one word, idling first at random; valid stays high after acceptance
   task automatic send_word(input req_word_type w);
      if (!steady && $urandom_range(99) < 20) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_opcode       <= w.op;
      req_node_index   <= w.idx;
      req_node_left    <= w.left;
      req_node_right   <= w.right;
      req_node_is_leaf <= w.leaf;
      req_node_symbol  <= w.sym;
      req_symbol_total <= w.total;
      req_code_byte    <= w.code;
      do @(posedge clock); while (!req_ready);
      if (w.op != OP_SPARE) items_fed++;
      if (w.op == OP_DECODE) bytes_fed++;
   endtask

   task automatic feed(input req_word_type w);
      send_word(w);
      decode_word(w);
      foreach (step_syms[k]) pending_syms.push_back(step_syms[k]);
   endtask

   // Drop valid, wait for every expected symbol, then let the sequencer drain
   task automatic settle();
      req_valid <= 1'b0;
      while (pending_syms.size() != 0) @(posedge clock);
      repeat (DRAIN_CYC) @(posedge clock);
   endtask

   task automatic write_root(input bit [IDX_W-1:0] r);
      csr_valid <= 1'b1;
      csr_root  <= r;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      root_sel = r;
      roots_set++;
   endtask

   // Random full binary tree under the current root, loaded in random order
   task automatic grow_tree(input int n_leaves);
      req_word_type   w;
      req_word_type   plan [$];
      int             k;
      bit [IDX_W-1:0] a;
      bit [IDX_W-1:0] b;
      foreach (taken[i]) taken[i] = 1'b0;
      taken[root_sel] = 1'b1;
      w      = rand_word(OP_LOAD);
      w.idx  = root_sel;
      w.leaf = 1'b1;
      plan.push_back(w);
      repeat (n_leaves - 1) begin
         do k = $urandom_range(plan.size() - 1); while (!plan[k].leaf);
         a       = fresh_index();
         b       = fresh_index();
         w       = plan[k];
         w.leaf  = 1'b0;
         w.left  = a;
         w.right = b;
         plan[k] = w;
         w       = rand_word(OP_LOAD);
         w.idx   = a;
         w.leaf  = 1'b1;
         plan.push_back(w);
         w.idx   = b;
         w.sym   = SYM_W'($urandom);
         plan.push_back(w);
      end
      live_tree = plan;
      while (plan.size() != 0) begin
         k = $urandom_range(plan.size() - 1);
         feed(plan[k]);
         plan.delete(k);
      end
   endtask

   // Load to an entry outside the live tree
   task automatic stray_load();
      req_word_type w;
      w = rand_word(OP_LOAD);
      while (taken[w.idx]) w.idx = IDX_W'($urandom);
      feed(w);
   endtask

   // Rewrite a live node: same shape, new symbol (and junk children on a leaf)
   task automatic relabel();
      req_word_type w;
      int           k;
      k     = $urandom_range(live_tree.size() - 1);
      w     = live_tree[k];
      w.sym = SYM_W'($urandom);
      if (w.leaf) begin
         w.left  = IDX_W'($urandom);
         w.right = IDX_W'($urandom);
      end
      w.total = $urandom;
      w.code  = BYTE_W'($urandom);
      live_tree[k] = w;
      feed(w);
   endtask

   task automatic start_stream(input bit [CNT_W-1:0] total);
      req_word_type w;
      w       = rand_word(OP_START);
      w.total = total;
      feed(w);
   endtask

   task automatic check_symbol();
      sym_word_type want;
      symbols_checked++;
      if (pending_syms.size() == 0) begin
         flag_error($sformatf("unexpected symbol %02h last %0b done %0b",
                              rsp_symbol, rsp_last, rsp_stream_done));
      end else begin
         want = pending_syms.pop_front();
         if (rsp_symbol !== want.symbol || rsp_last !== want.last ||
             rsp_stream_done !== want.stream_done)
            flag_error($sformatf("symbol exp %02h/%0b/%0b got %02h/%0b/%0b",
                                 want.symbol, want.last, want.stream_done,
                                 rsp_symbol, rsp_last, rsp_stream_done));
      end
   endtask

   // Receiver: checks each word, random ready, one long hold-off on request
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) check_symbol();
         if (rx_hold_left != 0) begin
            rx_hold_left = rx_hold_left - 1;
            if (rx_hold_left == 0) rx_hold_done = 1'b1;
            rsp_ready <= 1'b0;
         end else if (rx_hold_req && !rx_hold_done) begin
            rx_hold_left = HOLD_CYC;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= steady || ($urandom_range(99) >= 20);
         end
      end
   end

   initial begin
      int base;
      int phase;
      int n_bytes;
      int r;
      sym_word_type s;
      req_word_type w;

      // Directed: small tree at root 0 (reset value); A = 0, 0x00 = 10, 0xFF = 11
      dir_rows.push_back(expect_same(mk_row(OP_SPARE, 511, 511, 511, 1, 255, '1, 255),
                                     0, 0, 1'b0));
      dir_rows.push_back(mk_row(OP_LOAD,   0,   1,   2, 0, 8'h00, '0, 0));
      dir_rows.push_back(mk_row(OP_LOAD,   1, 511, 511, 1, 8'h41, '0, 0));
      dir_rows.push_back(mk_row(OP_LOAD,   2,   3,   4, 0, 8'h00, '0, 0));
      dir_rows.push_back(mk_row(OP_LOAD,   3,   0,   0, 1, 8'h00, '0, 0));
      dir_rows.push_back(mk_row(OP_LOAD,   4, 511,   0, 1, 8'hFF, '0, 0));
      dir_rows.push_back(mk_row(OP_LOAD, 511,   0, 511, 1, 8'hAA, '0, 0));
      dir_rows.push_back(mk_row(OP_START,  0,   0,   0, 0, 0, '1, 0));
      dir_rows.push_back(expect_same(mk_row(OP_DECODE, 0, 0, 0, 0, 0, '0, 8'h00),
                                     8, 8'h41, 1'b0));
      dir_rows.push_back(expect_same(mk_row(OP_DECODE, 0, 0, 0, 0, 0, '0, 8'hFF),
                                     4, 8'hFF, 1'b0));
      dir_rows.push_back(mk_row(OP_DECODE, 0, 0, 0, 0, 0, '0, 8'h5A));
      dir_rows.push_back(mk_row(OP_DECODE, 0, 0, 0, 0, 0, '0, 8'h80));
      // leaves the walk part way down the tree
      dir_rows.push_back(mk_row(OP_DECODE, 0, 0, 0, 0, 0, '0, 8'h01));
      dir_rows.push_back(mk_row(OP_START,  0, 0, 0, 0, 0, 32'd1, 0));
      dir_rows.push_back(expect_same(mk_row(OP_DECODE, 0, 0, 0, 0, 0, '0, 8'h00),
                                     1, 8'h41, 1'b1));
      // count exhausted: padding yields nothing
      dir_rows.push_back(expect_same(mk_row(OP_DECODE, 0, 0, 0, 0, 0, '0, 8'hFF),
                                     0, 0, 1'b0));
      dir_rows.push_back(mk_row(OP_START,  0, 0, 0, 0, 0, '0, 0));
      dir_rows.push_back(expect_same(mk_row(OP_DECODE, 0, 0, 0, 0, 0, '0, 8'h00),
                                     0, 0, 1'b0));
      dir_rows.push_back(expect_same(mk_row(OP_SPARE, 0, 0, 0, 0, 0, '0, 0), 0, 0, 1'b0));
      dir_rows.push_back(mk_row(OP_START,  0, 0, 0, 0, 0, 32'd3, 0));
      dir_rows.push_back(mk_row(OP_DECODE, 0, 0, 0, 0, 0, '0, 8'hC0));
      // leaf rewritten between streams
      dir_rows.push_back(mk_row(OP_LOAD,   3, 0, 0, 1, 8'h7E, '0, 0));
      dir_rows.push_back(mk_row(OP_START,  0, 0, 0, 0, 0, 32'd2, 0));
      dir_rows.push_back(mk_row(OP_DECODE, 0, 0, 0, 0, 0, '0, 8'h40));

      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (dir_rows[i]) begin
         send_word(dir_rows[i].w);
         decode_word(dir_rows[i].w);
         if (dir_rows[i].typed) begin
            for (int k = 0; k < dir_rows[i].exp_n; k++) begin
               s.symbol      = dir_rows[i].exp_sym;
               s.last        = (k == dir_rows[i].exp_n - 1);
               s.stream_done = dir_rows[i].done_on_tail && s.last;
               pending_syms.push_back(s);
            end
         end else begin
            foreach (step_syms[k]) pending_syms.push_back(step_syms[k]);
         end
      end

      // Random phases: new root, new tree, a stream of bytes with some noise and restarts
      base  = items_fed;
      phase = 0;
      while (items_fed - base < RAND_REQS) begin
         settle();
         write_root((phase == 0) ? 9'd511 : (phase == 1) ? 9'd0 : IDX_W'($urandom));
         steady = (phase == 3 || phase == 4);
         if (phase == 2) rx_hold_req = 1'b1;
         grow_tree(($urandom_range(9) == 0) ? $urandom_range(10, 32) : $urandom_range(2, 6));
         repeat ($urandom_range(0, 2)) stray_load();
         start_stream((phase == 2) ? '1 : pick_total());
         n_bytes = (phase == 2) ? 40 : $urandom_range(4, 14);
         repeat (n_bytes) begin
            r = $urandom_range(99);
            if (r < 80) begin
               feed(rand_word(OP_DECODE));
            end else if (r < 87) begin
               relabel();
            end else if (r < 93) begin
               start_stream(pick_total());
            end else if (r < 97) begin
               w = rand_word(OP_SPARE);
               feed(w);
            end else begin
               stray_load();
            end
         end
         phase++;
      end

      settle();
      $display("Covered %0d requests (%0d code bytes) across %0d root settings;",
               items_fed, bytes_fed, roots_set);
      $display("%0d symbols checked, %0d mismatches.", symbols_checked, err_count);
      if (err_count == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule

`default_nettype wire
